/* src/x86alu_pkg.sv */
// shared types, constants and helpers for the x86 integer alu
// no dependencies
package x86alu_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_ADC  = 5'd1,
    OP_SUB  = 5'd2,
    OP_SBB  = 5'd3,
    OP_MUL  = 5'd4,
    OP_IMUL = 5'd5,
    OP_DIV  = 5'd6,
    OP_IDIV = 5'd7,
    OP_MOD  = 5'd8,
    OP_IMOD = 5'd9,
    OP_AND  = 5'd10,
    OP_OR   = 5'd11,
    OP_XOR  = 5'd12,
    OP_SHL  = 5'd13,
    OP_SHR  = 5'd14,
    OP_SAR  = 5'd15,
    OP_SAL  = 5'd16
  } op_e;

  typedef enum logic [2:0] {
    CLS_ARITH,
    CLS_MUL,
    CLS_DIV,
    CLS_LOGIC,
    CLS_SHIFT,
    CLS_NONE
  } cls_e;

  localparam logic [1:0] W8  = 2'd0;
  localparam logic [1:0] W16 = 2'd1;
  localparam logic [1:0] W32 = 2'd2;

  typedef struct packed {
    op_e         op;
    cls_e        cls;
    logic [1:0]  wsel;
    logic [31:0] d;
    logic [31:0] s;
    logic [31:0] d_sx;
    logic [31:0] s_sx;
    logic [4:0]  shamt;
    logic [63:0] div_a;
    logic [31:0] div_b;
    logic        div_zero;
    logic        neg_q;
    logic        neg_r;
  } entry_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [QCntW-1:0] count;
  } qstat_t;

  typedef struct packed {
    logic of;
    logic sf;
    logic zf;
    logic pf;
    logic cf;
  } flags_t;

  function automatic logic [31:0] mask_w(input logic [1:0] wsel);
    logic [31:0] m;
    case (wsel)
      W8:      m = 32'h0000_00FF;
      W16:     m = 32'h0000_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic top_bit(input logic [31:0] v, input logic [1:0] wsel);
    logic b;
    case (wsel)
      W8:      b = v[7];
      W16:     b = v[15];
      default: b = v[31];
    endcase
    return b;
  endfunction

  function automatic logic [31:0] sext32(input logic [31:0] v, input logic [1:0] wsel);
    logic [31:0] r;
    case (wsel)
      W8:      r = {{24{v[7]}}, v[7:0]};
      W16:     r = {{16{v[15]}}, v[15:0]};
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

/* src/x86_integer_alu_with_flags_core.sv */
// Integer alu with kept carry, parity, zero, sign and overflow flags at 8, 16 or 32 bits.
// The front end decodes each input transaction into a two-entry queue; the back end executes
// it and holds one result register, so a new transaction is taken while a result waits.
// Add, adc, sub, sbb, logic and shift operations are done by the back end straight from its idle
// state; mul and imul register the 33 by 33 bit multiplier before the overflow check; div,
// idiv, mod and imod use the restoring divider, which forms one of 64 quotient bits per cycle;
// a zero divisor returns zero with the error bit and keeps flags.
// Depends on x86alu_pkg, x86alu_front, x86alu_queue and x86alu_back.
module x86_integer_alu_with_flags_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,  // operand_src, operand_dest
  input  logic [6:0]  s_axis_tuser_i,  // op, width_sel
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // result
  output logic [5:0]  m_axis_tuser_o   // carry_out, parity_out, zero_out, sign_out,
                                       // overflow_out, divide_error
);
  import x86alu_pkg::*;

  entry_t entry;
  entry_t head;
  qstat_t qstat;
  logic   push;
  logic   pop;
  logic   head_valid;

  x86alu_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .qstat_i         (qstat),
    .push_o          (push),
    .entry_o         (entry)
  );

  x86alu_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid),
    .qstat_o      (qstat)
  );

  x86alu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // divide error always returns zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[5]) |-> (m_axis_tdata_o == 64'd0))
    else $error("divide error with nonzero result");

  // queue occupancy stays within its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= QCntW'(QDepth))
    else $error("queue overfilled");

  // a pop only happens when an entry is present
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

/* src/x86alu_front.sv */
// front end: accepts transactions and classifies them into queue entries
// depends on x86alu_pkg
module x86alu_front (
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [95:0]           s_axis_tdata_i,  // operand_src, operand_dest
  input  logic [6:0]            s_axis_tuser_i,  // op, width_sel
  input  x86alu_pkg::qstat_t    qstat_i,
  output logic                  push_o,
  output x86alu_pkg::entry_t    entry_o
);
  import x86alu_pkg::*;

  logic [31:0] src;
  logic [63:0] dest;
  logic [1:0]  wsel;
  logic [31:0] m;
  op_e         op;
  logic        sgn;
  logic [63:0] a_raw;
  logic        na;
  logic        nb;

  assign src  = s_axis_tdata_i[31:0];
  assign dest = s_axis_tdata_i[95:32];
  assign op   = op_e'(s_axis_tuser_i[4:0]);
  assign wsel = (s_axis_tuser_i[6:5] == 2'd3) ? W32 : s_axis_tuser_i[6:5];
  assign m    = mask_w(wsel);
  assign sgn  = (op == OP_IDIV) || (op == OP_IMOD);

  assign s_axis_tready_o = !qstat_i.full;
  assign push_o          = s_axis_tvalid_i && !qstat_i.full;

  always_comb begin
    case (wsel)
      W8:      a_raw = sgn ? {{48{dest[15]}}, dest[15:0]} : {48'b0, dest[15:0]};
      W16:     a_raw = sgn ? {{32{dest[31]}}, dest[31:0]} : {32'b0, dest[31:0]};
      default: a_raw = dest;
    endcase
  end

  always_comb begin
    entry_o      = '0;
    entry_o.op   = op;
    entry_o.wsel = wsel;
    entry_o.d    = dest[31:0] & m;
    entry_o.s    = src & m;
    entry_o.d_sx = sext32(dest[31:0], wsel);
    entry_o.s_sx = sext32(src, wsel);
    case (wsel)
      W8:      entry_o.shamt = {2'b0, src[2:0]};
      W16:     entry_o.shamt = {1'b0, src[3:0]};
      default: entry_o.shamt = src[4:0];
    endcase
    na = sgn && a_raw[63];
    nb = sgn && entry_o.s_sx[31];
    entry_o.div_a    = na ? (64'd0 - a_raw) : a_raw;
    entry_o.div_b    = nb ? (32'd0 - entry_o.s_sx) : entry_o.s;
    entry_o.div_zero = (entry_o.s == 32'd0);
    entry_o.neg_q    = na ^ nb;
    entry_o.neg_r    = na;
    case (op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB:    entry_o.cls = CLS_ARITH;
      OP_MUL, OP_IMUL:                   entry_o.cls = CLS_MUL;
      OP_DIV, OP_IDIV, OP_MOD, OP_IMOD:  entry_o.cls = CLS_DIV;
      OP_AND, OP_OR, OP_XOR:             entry_o.cls = CLS_LOGIC;
      OP_SHL, OP_SHR, OP_SAR, OP_SAL:    entry_o.cls = CLS_SHIFT;
      default:                           entry_o.cls = CLS_NONE;
    endcase
  end

endmodule

/* src/x86alu_queue.sv */
// two-entry queue between front and back end
// depends on x86alu_pkg
module x86alu_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  x86alu_pkg::entry_t entry_i,
  input  logic               pop_i,
  output x86alu_pkg::entry_t head_o,
  output logic               head_valid_o,
  output x86alu_pkg::qstat_t qstat_o
);
  import x86alu_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_q;
  logic [QPtrW-1:0] rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push;
  logic             do_pop;

  assign do_push = push_i && (cnt_q != QCntW'(QDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  assign head_o        = mem_q[rd_q];
  assign head_valid_o  = (cnt_q != '0);
  assign qstat_o.full  = (cnt_q == QCntW'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign qstat_o.count = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

endmodule

/* src/x86alu_back.sv */
// back end: executes queued operations, keeps the flags, holds the result register
// depends on x86alu_pkg
module x86alu_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  x86alu_pkg::entry_t head_i,
  input  logic               head_valid_i,
  output logic               pop_o,
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [63:0]        m_axis_tdata_o,  // result
  output logic [5:0]         m_axis_tuser_o   // carry, parity, zero, sign, overflow, div error
);
  import x86alu_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_FIN} state_e;

  state_e      state_q;
  flags_t      flags_q;
  entry_t      ent_q;
  logic [63:0] prod_q;
  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [5:0]  cnt_q;
  logic        out_valid_q;
  logic [63:0] out_res_q;
  logic        out_derr_q;

  logic        can_load;
  logic        out_load;
  logic [63:0] sc_res;
  flags_t      sc_flags;
  logic        sc_derr;
  logic [31:0] r32;
  logic [31:0] m;
  logic [33:0] full;
  logic        cin;
  logic [5:0]  wbits;
  logic [5:0]  idx;
  logic [4:0]  cm1;

  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] mp;
  logic               msgn;

  logic [63:0] mf_res;
  flags_t      mf_flags;
  logic        mflag;

  logic [32:0] dv_t;
  logic        dv_ge;
  logic [32:0] dv_sub;
  logic [31:0] dq32;
  logic [31:0] dr32;
  logic [63:0] df_res;

  assign can_load        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q;
  assign m_axis_tuser_o  = {out_derr_q, flags_q.of, flags_q.sf, flags_q.zf,
                            flags_q.pf, flags_q.cf};

  // result register loads this cycle
  assign out_load = ((state_q == ST_IDLE) && pop_o && (head_i.cls != CLS_MUL) &&
                     !((head_i.cls == CLS_DIV) && !head_i.div_zero)) ||
                    (((state_q == ST_MUL) || (state_q == ST_FIN)) && can_load);

  // results formed straight from the queue head: add/sub, logic, shift and divide by zero
  always_comb begin
    m        = mask_w(head_i.wsel);
    sc_flags = flags_q;
    sc_derr  = 1'b0;
    r32      = '0;
    full     = '0;
    idx      = '0;
    cm1      = head_i.shamt - 5'd1;
    cin      = ((head_i.op == OP_ADC) || (head_i.op == OP_SBB)) && flags_q.cf;
    case (head_i.wsel)
      W8:      wbits = 6'd8;
      W16:     wbits = 6'd16;
      default: wbits = 6'd32;
    endcase
    case (head_i.cls)
      CLS_ARITH: begin
        if ((head_i.op == OP_ADD) || (head_i.op == OP_ADC)) begin
          full = {2'b0, head_i.d} + {2'b0, head_i.s} + {33'b0, cin};
          r32  = full[31:0] & m;
          sc_flags.of = (top_bit(head_i.d, head_i.wsel) == top_bit(head_i.s, head_i.wsel))
                        && (top_bit(r32, head_i.wsel) != top_bit(head_i.d, head_i.wsel));
          case (head_i.wsel)
            W8:      sc_flags.cf = full[8];
            W16:     sc_flags.cf = full[16];
            default: sc_flags.cf = full[32];
          endcase
        end else begin
          full = {2'b0, head_i.d} - {2'b0, head_i.s} - {33'b0, cin};
          r32  = full[31:0] & m;
          sc_flags.cf = full[33];
          sc_flags.of = (top_bit(head_i.d, head_i.wsel) != top_bit(head_i.s, head_i.wsel))
                        && (top_bit(r32, head_i.wsel) != top_bit(head_i.d, head_i.wsel));
        end
      end
      CLS_LOGIC: begin
        case (head_i.op)
          OP_AND:  r32 = head_i.d & head_i.s;
          OP_OR:   r32 = head_i.d | head_i.s;
          default: r32 = head_i.d ^ head_i.s;
        endcase
        sc_flags.cf = 1'b0;
        sc_flags.of = 1'b0;
      end
      CLS_SHIFT: begin
        idx = wbits - {1'b0, head_i.shamt};
        case (head_i.op)
          OP_SHL, OP_SAL: begin
            r32 = (head_i.d << head_i.shamt) & m;
            sc_flags.cf = (head_i.shamt != '0) && head_i.d[idx[4:0]];
          end
          OP_SHR: begin
            r32 = (head_i.d >> head_i.shamt) & m;
            sc_flags.cf = (head_i.shamt != '0) && head_i.d[cm1];
          end
          default: begin
            r32 = 32'($signed(head_i.d_sx) >>> head_i.shamt) & m;
            sc_flags.cf = (head_i.shamt != '0) && head_i.d[cm1];
          end
        endcase
      end
      CLS_DIV: sc_derr = 1'b1;
      default: r32 = '0;
    endcase
    if ((head_i.cls == CLS_ARITH) || (head_i.cls == CLS_LOGIC) ||
        (head_i.cls == CLS_SHIFT)) begin
      sc_flags.pf = ~^r32[7:0];
      sc_flags.zf = (r32 == 32'd0);
      sc_flags.sf = top_bit(r32, head_i.wsel);
    end
    sc_res = {32'b0, r32};
  end

  // multiplier, registered into prod_q
  always_comb begin
    msgn = (head_i.op == OP_IMUL);
    ma   = msgn ? $signed({head_i.d_sx[31], head_i.d_sx}) : $signed({1'b0, head_i.d});
    mb   = msgn ? $signed({head_i.s_sx[31], head_i.s_sx}) : $signed({1'b0, head_i.s});
    mp   = ma * mb;
  end

  always_comb begin
    mf_flags = flags_q;
    case (ent_q.wsel)
      W8: begin
        mf_res = {48'b0, prod_q[15:0]};
        mflag  = (ent_q.op == OP_IMUL) ? !((&prod_q[63:7]) || !(|prod_q[63:7]))
                                       : |prod_q[63:8];
      end
      W16: begin
        mf_res = {32'b0, prod_q[31:0]};
        mflag  = (ent_q.op == OP_IMUL) ? !((&prod_q[63:15]) || !(|prod_q[63:15]))
                                       : |prod_q[63:16];
      end
      default: begin
        mf_res = prod_q;
        mflag  = (ent_q.op == OP_IMUL) ? !((&prod_q[63:31]) || !(|prod_q[63:31]))
                                       : |prod_q[63:32];
      end
    endcase
    mf_flags.cf = mflag;
    mf_flags.of = mflag;
  end

  // restoring divider, one quotient bit per cycle
  always_comb begin
    dv_t   = {rem_q, quo_q[63]};
    dv_ge  = (dv_t >= {1'b0, ent_q.div_b});
    dv_sub = dv_t - {1'b0, ent_q.div_b};
    dq32   = ent_q.neg_q ? (32'd0 - quo_q[31:0]) : quo_q[31:0];
    dr32   = ent_q.neg_r ? (32'd0 - rem_q) : rem_q;
    df_res = {32'b0, (((ent_q.op == OP_DIV) || (ent_q.op == OP_IDIV)) ? dq32 : dr32)
                     & mask_w(ent_q.wsel)};
  end

  always_comb begin
    pop_o = 1'b0;
    if ((state_q == ST_IDLE) && head_valid_i) begin
      case (head_i.cls)
        CLS_MUL: pop_o = 1'b1;
        CLS_DIV: pop_o = head_i.div_zero ? can_load : 1'b1;
        default: pop_o = can_load;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_derr_q  <= 1'b0;
      ent_q       <= '0;
      prod_q      <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            ent_q <= head_i;
            if (head_i.cls == CLS_MUL) begin
              prod_q  <= mp[63:0];
              state_q <= ST_MUL;
            end else if ((head_i.cls == CLS_DIV) && !head_i.div_zero) begin
              quo_q   <= head_i.div_a;
              rem_q   <= '0;
              cnt_q   <= 6'd63;
              state_q <= ST_DIV;
            end else begin
              out_res_q   <= sc_res;
              out_derr_q  <= sc_derr;
              flags_q     <= sc_flags;
            end
          end
        end
        ST_MUL: begin
          if (can_load) begin
            out_res_q   <= mf_res;
            out_derr_q  <= 1'b0;
            flags_q     <= mf_flags;
            state_q     <= ST_IDLE;
          end
        end
        ST_DIV: begin
          quo_q <= {quo_q[62:0], dv_ge};
          rem_q <= dv_ge ? dv_sub[31:0] : dv_t[31:0];
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == '0) state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (can_load) begin
            out_res_q   <= df_res;
            out_derr_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
